// ===== rtl/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg: shared types and constants of the text mode console writer
// Command codes, character codes, cell update operations and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int CELL_W = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SETBG = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_HI_MASK = 8'hf0;
  localparam logic [7:0] ATTR_LO_MASK = 8'h0f;
  localparam logic [7:0] BG_MIN       = 8'h10;

  // Read-modify-write operation applied to one cell
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_COPY    = 3'd1,
    OP_CLRCHAR = 3'd2,
    OP_ZERO    = 3'd3,
    OP_PUTCH   = 3'd4,
    OP_PUTSP   = 3'd5,
    OP_MARK    = 3'd6,
    OP_BGADD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ADDR_CNT    = 2'd0,
    ADDR_POS    = 2'd1,
    ADDR_POS_M1 = 2'd2,
    ADDR_IDX    = 2'd3
  } addr_sel_t;

  typedef enum logic [1:0] {
    CNT_ZERO = 2'd0,
    CNT_ROW  = 2'd1,
    CNT_BOT  = 2'd2
  } cnt_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_CLR    = 3'd1,
    POS_SCROLL = 3'd2,
    POS_INC    = 3'd3,
    POS_DEC    = 3'd4
  } pos_op_t;

  typedef struct packed {
    logic is_write;
    logic is_clear;
    logic is_setbg;
    logic is_read;
    logic ch_nul;
    logic ch_nl;
    logic ch_bs;
    logic ch_cr;
    logic ch_tab;
    logic eos;
    logic bg_add;
  } item_dec_t;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    addr_sel_t addr_sel;
    op_t       op;
    logic      cnt_load;
    cnt_sel_t  cnt_sel;
    logic      cnt_inc;
    pos_op_t   pos_op;
    logic      out_fire;
    logic      out_written;
    logic      out_read;
  } dp_cmd_t;

  typedef struct packed {
    item_dec_t in_dec;
    item_dec_t item_dec;
    logic      pos_end;
    logic      pos_zero;
    logic      pos_last;
    logic      col_zero;
    logic      col_one;
    logic      col_last;
    logic      tab_last;
    logic      cnt_last;
  } dp_status_t;

  function automatic item_dec_t item_decode(logic [1:0] cmd, logic [7:0] ch,
                                            logic [7:0] color, logic eos);
    item_dec_t d;
    d.is_write = (cmd == CMD_WRITE);
    d.is_clear = (cmd == CMD_CLEAR);
    d.is_setbg = (cmd == CMD_SETBG);
    d.is_read  = (cmd == CMD_READ);
    d.ch_nul   = (ch == CH_NUL);
    d.ch_nl    = (ch == CH_NL);
    d.ch_bs    = (ch == CH_BS);
    d.ch_cr    = (ch == CH_CR);
    d.ch_tab   = (ch == CH_TAB);
    d.eos      = eos;
    d.bg_add   = (color >= BG_MIN);
    return d;
  endfunction

endpackage

// ===== rtl/tmcw_ram.sv =====
// ----------------------------------------------------------------------------
// tmcw_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tmcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmcw_ctrl: console writer controller
// Sequences each command into cell read-modify-write steps and sweeps.
// ----------------------------------------------------------------------------
module tmcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output tmcw_pkg::dp_cmd_t    cmd,
  input  tmcw_pkg::dp_status_t status
);

  typedef enum logic [13:0] {
    S_INIT    = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_SCROLL  = 14'b00000000000100,
    S_BOTCLR  = 14'b00000000001000,
    S_NEWLINE = 14'b00000000010000,
    S_CR      = 14'b00000000100000,
    S_BS      = 14'b00000001000000,
    S_TAB     = 14'b00000010000000,
    S_PUT     = 14'b00000100000000,
    S_MARK    = 14'b00001000000000,
    S_BGADD   = 14'b00010000000000,
    S_CLEAR   = 14'b00100000000000,
    S_READ    = 14'b01000000000000,
    S_RDOUT   = 14'b10000000000000
  } state_t;

  state_t              state_r, state_nxt;
  state_t              char_state;
  tmcw_pkg::item_dec_t dsp;
  logic                char_nop;
  logic                dispatch;
  logic                end_char;

  // In idle the item is still on the input ports; afterward use the latched copy
  assign dsp = (state_r == S_IDLE) ? status.in_dec : status.item_dec;

  assign char_nop = (dsp.ch_bs && status.pos_zero) || (dsp.ch_cr && status.col_zero);

  always_comb begin
    if (dsp.ch_nl) begin
      char_state = S_NEWLINE;
    end else if (dsp.ch_bs) begin
      char_state = S_BS;
    end else if (dsp.ch_cr) begin
      char_state = S_CR;
    end else if (dsp.ch_tab) begin
      char_state = S_TAB;
    end else begin
      char_state = S_PUT;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    dispatch        = 1'b0;
    end_char        = 1'b0;
    cmd.latch       = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.addr_sel    = tmcw_pkg::ADDR_CNT;
    cmd.op          = tmcw_pkg::OP_NONE;
    cmd.cnt_load    = 1'b0;
    cmd.cnt_sel     = tmcw_pkg::CNT_ZERO;
    cmd.cnt_inc     = 1'b0;
    cmd.pos_op      = tmcw_pkg::POS_HOLD;
    cmd.out_fire    = 1'b0;
    cmd.out_written = 1'b0;
    cmd.out_read    = 1'b0;

    case (state_r)
      S_INIT: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = tmcw_pkg::OP_ZERO;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (status.in_dec.is_write) begin
            if (!status.in_dec.ch_nul) begin
              if (status.pos_end) begin
                cmd.pos_op   = tmcw_pkg::POS_SCROLL;
                cmd.cnt_load = 1'b1;
                cmd.cnt_sel  = tmcw_pkg::CNT_ROW;
                state_nxt    = S_SCROLL;
              end else begin
                dispatch = 1'b1;
              end
            end else if (status.in_dec.eos) begin
              state_nxt = S_MARK;
            end else begin
              cmd.out_fire = 1'b1;
            end
          end else if (status.in_dec.is_clear) begin
            cmd.pos_op   = tmcw_pkg::POS_CLR;
            cmd.cnt_load = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (status.in_dec.is_setbg) begin
            cmd.pos_op = tmcw_pkg::POS_CLR;
            if (status.in_dec.bg_add) begin
              cmd.cnt_load = 1'b1;
              state_nxt    = S_BGADD;
            end else begin
              state_nxt = S_MARK;
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SCROLL: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = tmcw_pkg::OP_COPY;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_load = 1'b1;
          cmd.cnt_sel  = tmcw_pkg::CNT_BOT;
          state_nxt    = S_BOTCLR;
        end
      end
      S_BOTCLR: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = tmcw_pkg::OP_CLRCHAR;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          dispatch = 1'b1;
        end
      end
      S_NEWLINE: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_POS;
        cmd.op       = tmcw_pkg::OP_CLRCHAR;
        cmd.pos_op   = tmcw_pkg::POS_INC;
        end_char     = status.col_last;
      end
      S_CR: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_POS_M1;
        cmd.op       = tmcw_pkg::OP_CLRCHAR;
        cmd.pos_op   = tmcw_pkg::POS_DEC;
        end_char     = status.col_one;
      end
      S_BS: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_POS_M1;
        cmd.op       = tmcw_pkg::OP_CLRCHAR;
        cmd.pos_op   = tmcw_pkg::POS_DEC;
        end_char     = 1'b1;
      end
      S_TAB: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_POS;
        cmd.op       = tmcw_pkg::OP_PUTSP;
        cmd.pos_op   = tmcw_pkg::POS_INC;
        end_char     = status.tab_last || status.pos_last;
      end
      S_PUT: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_POS;
        cmd.op       = tmcw_pkg::OP_PUTCH;
        cmd.pos_op   = tmcw_pkg::POS_INC;
        end_char     = 1'b1;
      end
      S_MARK: begin
        cmd.rd_en       = !status.pos_end;
        cmd.addr_sel    = tmcw_pkg::ADDR_POS;
        cmd.op          = tmcw_pkg::OP_MARK;
        cmd.out_fire    = 1'b1;
        cmd.out_written = status.item_dec.is_write && !status.item_dec.ch_nul;
        state_nxt       = S_IDLE;
      end
      S_BGADD: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = tmcw_pkg::OP_BGADD;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          state_nxt = S_MARK;
        end
      end
      S_CLEAR: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = tmcw_pkg::OP_ZERO;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          cmd.out_fire = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tmcw_pkg::ADDR_IDX;
        state_nxt    = S_RDOUT;
      end
      S_RDOUT: begin
        cmd.out_fire = 1'b1;
        cmd.out_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (dispatch) begin
      if (char_nop) begin
        end_char = 1'b1;
      end else begin
        state_nxt = char_state;
      end
    end

    if (end_char) begin
      if (dsp.eos) begin
        state_nxt = S_MARK;
      end else begin
        cmd.out_fire    = 1'b1;
        cmd.out_written = 1'b1;
        state_nxt       = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/tmcw_dp.sv =====
// ----------------------------------------------------------------------------
// tmcw_dp: console writer datapath
// Screen memory with a one-stage read-modify-write pipe, write position with
// column and tab counters, sweep counter and result registers.
// ----------------------------------------------------------------------------
module tmcw_dp #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_color,
  input  logic                  in_end_of_string,
  input  logic [10:0]           in_cell_index,
  input  tmcw_pkg::dp_cmd_t     cmd,
  output tmcw_pkg::dp_status_t  status,
  output logic                  out_valid,
  output logic [10:0]           out_cursor_position,
  output logic                  out_written,
  output logic [7:0]            out_read_char,
  output logic [7:0]            out_read_attr
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int POS_W      = $clog2(CELLS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int TAB_W      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int SCROLL_TAB = (CELLS - COLUMNS) % TAB_STOP;
  localparam int CW         = tmcw_pkg::CELL_W;

  logic [1:0]        item_cmd_r;
  logic [7:0]        item_char_r;
  logic [7:0]        item_color_r;
  logic              item_eos_r;
  logic [10:0]       item_idx_r;
  logic              idx_ok;

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_m1;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [TAB_W-1:0]  tab_r, tab_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  logic [ADDR_W-1:0] rd_addr;
  logic [CW-1:0]     ram_q, rdata, wdata;
  logic              wp_en_r;
  tmcw_pkg::op_t     wp_op_r;
  logic [ADDR_W-1:0] wp_addr_r;
  logic              fwd_hit_r;
  logic [CW-1:0]     fwd_data_r;
  logic [7:0]        attr_sum;

  logic              out_valid_r;
  logic [10:0]       out_cursor_r;
  logic              out_written_r;
  logic [7:0]        out_char_r, out_attr_r;

  // Item capture at accept
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd_r   <= in_cmd;
      item_char_r  <= in_char_code;
      item_color_r <= in_color;
      item_eos_r   <= in_end_of_string;
      item_idx_r   <= in_cell_index;
    end
  end

  assign idx_ok = (32'(item_idx_r) < 32'(CELLS));
  assign pos_m1 = pos_r - 1'b1;

  // Write position with its column and tab stop phase
  always_comb begin
    pos_nxt = pos_r;
    col_nxt = col_r;
    tab_nxt = tab_r;
    case (cmd.pos_op)
      tmcw_pkg::POS_CLR: begin
        pos_nxt = '0;
        col_nxt = '0;
        tab_nxt = '0;
      end
      tmcw_pkg::POS_SCROLL: begin
        pos_nxt = POS_W'(CELLS - COLUMNS);
        col_nxt = '0;
        tab_nxt = TAB_W'(SCROLL_TAB);
      end
      tmcw_pkg::POS_INC: begin
        pos_nxt = pos_r + 1'b1;
        col_nxt = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
        tab_nxt = (tab_r == TAB_W'(TAB_STOP - 1)) ? '0 : tab_r + 1'b1;
      end
      tmcw_pkg::POS_DEC: begin
        pos_nxt = pos_m1;
        col_nxt = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;
        tab_nxt = (tab_r == '0) ? TAB_W'(TAB_STOP - 1) : tab_r - 1'b1;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // Sweep counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_load) begin
      case (cmd.cnt_sel)
        tmcw_pkg::CNT_ROW: cnt_nxt = ADDR_W'(COLUMNS);
        tmcw_pkg::CNT_BOT: cnt_nxt = ADDR_W'(CELLS - COLUMNS);
        default:           cnt_nxt = '0;
      endcase
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      col_r <= '0;
      tab_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      tab_r <= tab_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      tmcw_pkg::ADDR_POS:    rd_addr = pos_r[ADDR_W-1:0];
      tmcw_pkg::ADDR_POS_M1: rd_addr = pos_m1[ADDR_W-1:0];
      tmcw_pkg::ADDR_IDX:    rd_addr = ADDR_W'(item_idx_r);
      default:               rd_addr = cnt_r;
    endcase
  end

  tmcw_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (wp_en_r),
    .waddr (wp_addr_r),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // A read that hit the cell being written gets the new value
  assign rdata    = fwd_hit_r ? fwd_data_r : ram_q;
  assign attr_sum = (rdata[15:8] & tmcw_pkg::ATTR_LO_MASK) + item_color_r;

  always_comb begin
    case (wp_op_r)
      tmcw_pkg::OP_CLRCHAR: wdata = {rdata[15:8], tmcw_pkg::CH_NUL};
      tmcw_pkg::OP_ZERO:    wdata = '0;
      tmcw_pkg::OP_PUTCH:
        wdata = {(rdata[15:8] & tmcw_pkg::ATTR_HI_MASK) | item_color_r, item_char_r};
      tmcw_pkg::OP_PUTSP:
        wdata = {(rdata[15:8] & tmcw_pkg::ATTR_HI_MASK) | item_color_r, tmcw_pkg::CH_SPACE};
      tmcw_pkg::OP_MARK:
        wdata = {rdata[15:8] | (item_color_r & tmcw_pkg::ATTR_LO_MASK), rdata[7:0]};
      tmcw_pkg::OP_BGADD:   wdata = {attr_sum, rdata[7:0]};
      default:              wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_en_r <= 1'b0;
    end else begin
      wp_en_r <= cmd.rd_en && (cmd.op != tmcw_pkg::OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    wp_op_r    <= cmd.op;
    wp_addr_r  <= (cmd.op == tmcw_pkg::OP_COPY) ? rd_addr - ADDR_W'(COLUMNS) : rd_addr;
    fwd_hit_r  <= cmd.rd_en && wp_en_r && (rd_addr == wp_addr_r);
    fwd_data_r <= wdata;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_cursor_r  <= 11'(pos_nxt);
      out_written_r <= cmd.out_written;
      out_char_r    <= (cmd.out_read && idx_ok) ? rdata[7:0] : 8'h00;
      out_attr_r    <= (cmd.out_read && idx_ok) ? rdata[15:8] : 8'h00;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_written         = out_written_r;
  assign out_read_char       = out_char_r;
  assign out_read_attr       = out_attr_r;

  always_comb begin
    status.in_dec   = tmcw_pkg::item_decode(in_cmd, in_char_code, in_color, in_end_of_string);
    status.item_dec = tmcw_pkg::item_decode(item_cmd_r, item_char_r, item_color_r,
                                            item_eos_r);
    status.pos_end  = (pos_r == POS_W'(CELLS));
    status.pos_zero = (pos_r == '0);
    status.pos_last = (pos_r == POS_W'(CELLS - 1));
    status.col_zero = (col_r == '0);
    status.col_one  = (col_r == COL_W'(1));
    status.col_last = (col_r == COL_W'(COLUMNS - 1));
    status.tab_last = (tab_r == TAB_W'(TAB_STOP - 1));
    status.cnt_last = (cnt_r == ADDR_W'(CELLS - 1));
  end

endmodule

// ===== rtl/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer: text screen writer with scroll and cell reads
// Holds a ROWS x COLUMNS screen of character/attribute cells and a write
// position; writes characters, clears, sets the background and reads cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low. Every
//   item gives one result on the out_ ports, shown for one cycle with
//   out_valid high; the receiver cannot stall, so capture it then.
//   Work from accept to the next possible accept:
//     NUL without end_of_string    no cell access
//     ordinary character           one cell read-modify-write
//     with end_of_string           adds a cursor cell mark
//     newline                      erases characters to the end of the row
//     carriage return              erases characters back to column 0
//     tab                          writes spaces up to the next tab stop
//     write at end of screen       adds a row copy up, then a bottom row clear
//     clear screen                 zeroes every cell
//     set background               optional attribute sweep, then cell 0 mark
//     read cell                    one cell read, then the result
//   The screen memory has a single write port: one cell is updated per
//   cycle, and reads overlap the previous cell's write.
//   After reset busy stays high while a clearing pass zeroes every cell;
//   the write position starts at cell 0.
// ----------------------------------------------------------------------------
module text_mode_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_color,
  input  logic        in_end_of_string,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_position,
  output logic        out_written,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr
);

  tmcw_pkg::dp_cmd_t    dp_cmd;
  tmcw_pkg::dp_status_t dp_status;

  // Controller: sequence each transfer into cell steps
  tmcw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (dp_cmd),
    .status (dp_status)
  );

  // Datapath: screen memory, position counters, result registers
  tmcw_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_cmd              (in_cmd),
    .in_char_code        (in_char_code),
    .in_color            (in_color),
    .in_end_of_string    (in_end_of_string),
    .in_cell_index       (in_cell_index),
    .cmd                 (dp_cmd),
    .status              (dp_status),
    .out_valid           (out_valid),
    .out_cursor_position (out_cursor_position),
    .out_written         (out_written),
    .out_read_char       (out_read_char),
    .out_read_attr       (out_read_attr)
  );

  // A result always comes from an accepted transfer or work in progress
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && !busy)))
    else $error("result strobe without a transfer in progress");

  // The block is free again whenever a result is shown
  a_result_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // Never touch a cell at the write position once it is past the end
  a_no_access_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.rd_en && (dp_cmd.addr_sel == tmcw_pkg::ADDR_POS)) |-> !dp_status.pos_end)
    else $error("cell access at write position past end of screen");

endmodule

// ===== tb/sv/tmcw_screen_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_screen_checker: result checker for the text mode console writer
// Watches the command and result channels, keeps its own copy of the screen
// and write position, works out the result of each accepted command and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tmcw_screen_checker
  import tmcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_color,
  input  logic        in_end_of_string,
  input  logic [10:0] in_cell_index,
  input  logic        out_valid,
  input  logic [10:0] out_cursor_position,
  input  logic        out_written,
  input  logic [7:0]  out_read_char,
  input  logic [7:0]  out_read_attr,
  output int          failures,
  output int          outstanding,
  output int          results_checked,
  output int          scrolls
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [10:0] cursor;
    logic        written;
    logic [7:0]  rd_char;
    logic [7:0]  rd_attr;
  } screen_result_t;

  logic [15:0]    screen [CELLS];
  int unsigned    cursor;
  screen_result_t pending_screen_results [$];

  initial begin
    failures        = 0;
    outstanding     = 0;
    results_checked = 0;
    scrolls         = 0;
  end

  function automatic void erase_char(int unsigned p);
    if (p < CELLS) screen[p][7:0] = CH_NUL;
  endfunction

  function automatic void put_colored(int unsigned p, logic [7:0] ch, logic [7:0] color);
    if (p < CELLS) screen[p] = {(screen[p][15:8] & ATTR_HI_MASK) | color, ch};
  endfunction

  function automatic void mark_cursor_cell(logic [7:0] color);
    if (cursor < CELLS) screen[cursor][15:8] = screen[cursor][15:8] | (color & ATTR_LO_MASK);
  endfunction

  function automatic screen_result_t run_console_cmd(cmd_t cmd, logic [7:0] ch,
                                                     logic [7:0] color, logic eos,
                                                     logic [10:0] idx);
    screen_result_t r;
    int unsigned    i;
    int unsigned    n;
    logic [7:0]     attr;
    r = '0;
    case (cmd)
      CMD_WRITE: begin
        if (ch != CH_NUL) begin
          // past the end: scroll up one row, blank the bottom row's characters
          if (cursor >= CELLS) begin
            cursor = CELLS - COLUMNS;
            for (i = COLUMNS; i < CELLS; i++) screen[i - COLUMNS] = screen[i];
            for (i = CELLS - COLUMNS; i < CELLS; i++) erase_char(i);
            scrolls++;
          end
          case (ch)
            CH_NL: begin
              n = COLUMNS - (cursor % COLUMNS);
              for (i = 0; i < n; i++) begin
                erase_char(cursor);
                cursor++;
              end
            end
            CH_BS: begin
              if (cursor >= 1) begin
                cursor--;
                erase_char(cursor);
              end
            end
            CH_CR: begin
              n = cursor % COLUMNS;
              for (i = 0; i < n; i++) begin
                cursor--;
                erase_char(cursor);
              end
            end
            CH_TAB: begin
              n = TAB_STOP - (cursor % TAB_STOP);
              for (i = 0; i < n && cursor < CELLS; i++) begin
                put_colored(cursor, CH_SPACE, color);
                cursor++;
              end
            end
            default: begin
              put_colored(cursor, ch, color);
              cursor++;
            end
          endcase
          r.written = 1'b1;
        end
        if (eos) mark_cursor_cell(color);
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = '0;
        cursor = 0;
      end
      CMD_SETBG: begin
        cursor = 0;
        if (color >= BG_MIN) begin
          for (i = 0; i < CELLS; i++) begin
            attr = {4'h0, screen[i][11:8]} + color;
            screen[i][15:8] = attr;
          end
        end
        mark_cursor_cell(color);
      end
      default: begin
        if (idx < CELLS) begin
          r.rd_char = screen[idx][7:0];
          r.rd_attr = screen[idx][15:8];
        end
      end
    endcase
    r.cursor = cursor[10:0];
    return r;
  endfunction

  function automatic void log_failure(string what);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, what);
  endfunction

  always @(posedge clk) begin : watch
    screen_result_t want;
    screen_result_t seen;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) screen[k] = '0;
      cursor = 0;
      pending_screen_results.delete();
    end else begin
      // push before pop, so a same-edge result still finds its item
      if (start === 1'b1 && busy === 1'b0)
        pending_screen_results.push_back(run_console_cmd(cmd_t'(in_cmd), in_char_code,
                                                         in_color, in_end_of_string,
                                                         in_cell_index));
      if (out_valid === 1'b1) begin
        seen = {out_cursor_position, out_written, out_read_char, out_read_attr};
        if (pending_screen_results.size() == 0) begin
          log_failure($sformatf("result with no command waiting: cursor=%0d written=%0b char=%02h attr=%02h",
                                seen.cursor, seen.written, seen.rd_char, seen.rd_attr));
        end else begin
          want = pending_screen_results.pop_front();
          results_checked++;
          if (seen !== want)
            log_failure($sformatf({"mismatch: expected cursor=%0d written=%0b char=%02h attr=%02h,",
                                   " got cursor=%0d written=%0b char=%02h attr=%02h"},
                                  want.cursor, want.written, want.rd_char, want.rd_attr,
                                  seen.cursor, seen.written, seen.rd_char, seen.rd_attr));
        end
      end
    end
    outstanding = pending_screen_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text mode console writer
// Drives directed and random command streams (character strings, clears,
// background changes and cell reads) with random gaps, while the screen
// checker predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import tmcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int N_ITEMS  = 1650;
  // worst item: scroll, then a full row walk, then the mark, plus a sender gap
  localparam int LIMIT    = 2 * CELLS + (N_ITEMS + 50) * (2 * CELLS + COLUMNS + 40) * 2;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [7:0]  in_char_code;
  logic [7:0]  in_color;
  logic        in_end_of_string;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic [10:0] out_cursor_position;
  logic        out_written;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;

  int failures;
  int outstanding;
  int results_checked;
  int scrolls;
  int cycles;
  int transfers;
  bit steady;

  text_mode_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_color           (in_color),
    .in_end_of_string   (in_end_of_string),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_cursor_position(out_cursor_position),
    .out_written        (out_written),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr)
  );

  tmcw_screen_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_color           (in_color),
    .in_end_of_string   (in_end_of_string),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_cursor_position(out_cursor_position),
    .out_written        (out_written),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .failures           (failures),
    .outstanding        (outstanding),
    .results_checked    (results_checked),
    .scrolls            (scrolls)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: end the run once the cycle count reaches LIMIT
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command from the falling edge and hold it until the block
  // takes it (start high, busy low at a rising edge); return on the next
  // falling edge with start still high so back-to-back transfers stay glued.
  task automatic issue_cmd(cmd_t cmd, logic [7:0] ch, logic [7:0] color, logic eos,
                           logic [10:0] idx);
    start            = 1'b1;
    in_cmd           = cmd;
    in_char_code     = ch;
    in_color         = color;
    in_end_of_string = eos;
    in_cell_index    = idx;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    transfers++;
  endtask

  // Drop start for a random pause about 9 times in 100, except in the steady
  // stretch; scramble the fields while idle so stale values never matter.
  task automatic maybe_pause();
    if (!steady && $urandom_range(0, 99) < 9) begin
      start            = 1'b0;
      in_cmd           = 2'($urandom_range(0, 3));
      in_char_code     = 8'($urandom_range(0, 255));
      in_color         = 8'($urandom_range(0, 255));
      in_end_of_string = 1'($urandom_range(0, 1));
      in_cell_index    = 11'($urandom_range(0, 2047));
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Mostly printable text, with a fair share of control characters
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)      return 8'($urandom_range(8'h21, 8'h7e));
    else if (r < 70) return CH_NL;
    else if (r < 74) return CH_TAB;
    else if (r < 77) return CH_BS;
    else if (r < 80) return CH_CR;
    else if (r < 82) return CH_NUL;
    else             return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int          sel;
    int          len;
    logic [7:0]  color;
    logic [10:0] idx;
    transfers        = 0;
    steady           = 1'b0;
    start            = 1'b0;
    in_cmd           = CMD_WRITE;
    in_char_code     = CH_NUL;
    in_color         = 8'h00;
    in_end_of_string = 1'b0;
    in_cell_index    = '0;
    rst_n            = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: control characters, color extremes, edge cells.
    // The clearing pass after reset is absorbed by the handshake.
    issue_cmd(CMD_WRITE, 8'h41, 8'hff, 1'b0, 11'd0);     // full color byte
    issue_cmd(CMD_WRITE, 8'h42, 8'h00, 1'b1, 11'd0);     // mark cursor cell
    issue_cmd(CMD_WRITE, CH_NUL, 8'h0f, 1'b1, 11'd0);    // NUL still marks
    issue_cmd(CMD_WRITE, CH_TAB, 8'h1e, 1'b0, 11'd0);
    issue_cmd(CMD_WRITE, CH_NL, 8'h07, 1'b1, 11'd0);
    issue_cmd(CMD_WRITE, CH_NL, 8'h07, 1'b0, 11'd0);     // newline at column 0
    issue_cmd(CMD_WRITE, 8'h78, 8'h5a, 1'b0, 11'd0);
    issue_cmd(CMD_WRITE, CH_CR, 8'h5a, 1'b0, 11'd0);     // erase back to column 0
    issue_cmd(CMD_WRITE, CH_BS, 8'h5a, 1'b1, 11'd0);     // back into previous row
    issue_cmd(CMD_READ, 8'hff, 8'hff, 1'b1, 11'd0);
    issue_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, 11'd1999);
    issue_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, 11'd2047);   // out of range
    issue_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, 11'd2000);
    issue_cmd(CMD_CLEAR, 8'h00, 8'h00, 1'b0, 11'd0);
    issue_cmd(CMD_WRITE, CH_BS, 8'h33, 1'b1, 11'd0);     // backspace at cell 0
    issue_cmd(CMD_SETBG, 8'h00, 8'h07, 1'b0, 11'd0);     // below threshold
    issue_cmd(CMD_WRITE, 8'h51, 8'h3c, 1'b1, 11'd0);
    issue_cmd(CMD_SETBG, 8'h00, 8'hff, 1'b0, 11'd0);     // attribute wrap
    issue_cmd(CMD_SETBG, 8'h00, 8'h10, 1'b1, 11'd0);     // exact threshold
    issue_cmd(CMD_WRITE, 8'hff, 8'ha5, 1'b1, 11'd0);
    issue_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, 11'd0);
    issue_cmd(CMD_READ, 8'h00, 8'h00, 1'b0, 11'd1);
    issue_cmd(CMD_CLEAR, 8'hff, 8'hff, 1'b1, 11'h7ff);

    // Random part: mostly strings ending in end_of_string, reads sprinkled
    // between them, rare clears and background changes so the screen fills
    // up and scrolls.
    while (transfers < N_ITEMS) begin
      steady = (transfers >= 700 && transfers < 1000);
      sel = $urandom_range(0, 199);
      if (sel < 140) begin
        len   = $urandom_range(1, 30);
        color = 8'($urandom_range(0, 255));
        for (int k = 0; k < len; k++) begin
          maybe_pause();
          if ($urandom_range(0, 7) == 0) color = 8'($urandom_range(0, 255));
          issue_cmd(CMD_WRITE, pick_char(), color,
                    (k == len - 1) || ($urandom_range(0, 19) == 0),
                    11'($urandom_range(0, 2047)));
        end
      end else if (sel < 194) begin
        repeat ($urandom_range(1, 4)) begin
          maybe_pause();
          idx = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                            : 11'($urandom_range(0, CELLS - 1));
          issue_cmd(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), idx);
        end
      end else if (sel < 197) begin
        maybe_pause();
        color = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                     : 8'($urandom_range(0, 255));
        issue_cmd(CMD_SETBG, 8'($urandom_range(0, 255)), color, 1'($urandom_range(0, 1)),
                  11'($urandom_range(0, 2047)));
      end else begin
        maybe_pause();
        issue_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
      end
    end
    start = 1'b0;

    // Drain: wait for every expected result, then hold on long enough to
    // catch any stray result from a long walk.
    while (outstanding != 0) @(posedge clk);
    repeat (2 * CELLS + 100) @(posedge clk);

    $display("%0d commands transferred, %0d results checked, %0d scrolls seen",
             transfers, results_checked, scrolls);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", failures);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== text_mode_console_writer.f =====
rtl/tmcw_pkg.sv
rtl/tmcw_ram.sv
rtl/tmcw_ctrl.sv
rtl/tmcw_dp.sv
rtl/text_mode_console_writer.sv
tb/sv/tmcw_screen_checker.sv
tb/sv/tb_top.sv
